FILE: design/pct_pkg.sv
// Package for the prime test and count block.
// Holds shared widths, defaults and the status type of the remainder unit.
// No dependencies.
package pct_pkg;

    // Default width of the value under test
    localparam int VALUE_WIDTH = 32;

    // Fixed field and bus widths
    localparam int IN_DATA_W  = 32;
    localparam int COUNT_W    = 28;
    localparam int OUT_DATA_W = 32;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;      // remainder is final this cycle
        logic zero;      // remainder is zero (divisor divides the value)
    } t_rem_stat;

endpackage

FILE: design/prime_test_and_count.sv
// Prime test and count: trial division by a shared bit-serial remainder unit.
// Test mode: the value itself is the only candidate, tried against divisors d while d*d <= n.
// Count mode: every candidate from 2 to n is tested in turn and the primes are counted.
// The remainder unit (one bit per cycle) sets the pace; one request at a time.
// Synchronous active-low reset clears the sequencer and the output valid.
module prime_test_and_count #(
    parameter int VALUE_WIDTH = pct_pkg::VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pct_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // value
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pct_pkg::OUT_DATA_W-1:0] m_axis_tdata   // is_prime, prime_count, zero pad
);

    localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W  = VALUE_WIDTH + 2;
    localparam int CW    = pct_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAND = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RES  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic                   r_op, n_op;
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [VALUE_WIDTH-1:0] r_c, n_c;
    logic [DIV_W-1:0]       r_d, n_d;
    logic [SQ_W-1:0]        r_sq, n_sq;
    logic                   r_cprime, n_cprime;
    logic                   r_fprime, n_fprime;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_ovalid;
    logic                   r_oprime;
    logic [CW-1:0]          r_ocnt;

    logic                   w_start;
    logic                   w_load;
    pct_pkg::t_rem_stat     w_stat;

    // Shared remainder unit
    pct_rem #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_W       (DIV_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_c),
        .i_divisor  (r_d),
        .o_stat     (w_stat)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_load        = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    // Sequencer: walk candidates and trial divisors
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_n      = r_n;
        n_c      = r_c;
        n_d      = r_d;
        n_sq     = r_sq;
        n_cprime = r_cprime;
        n_fprime = r_fprime;
        n_count  = r_count;
        w_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_n     = s_axis_tdata[VALUE_WIDTH-1:0];
                    n_count = '0;
                    // Count mode starts at two; below two only the value itself is seen
                    if (s_axis_tuser && (s_axis_tdata[VALUE_WIDTH-1:0] > VALUE_WIDTH'(1))) begin
                        n_c = VALUE_WIDTH'(2);
                    end else begin
                        n_c = s_axis_tdata[VALUE_WIDTH-1:0];
                    end
                    n_state = ST_CAND;
                end
            end
            ST_CAND: begin
                n_d  = DIV_W'(2);
                n_sq = SQ_W'(4);
                if (r_c < VALUE_WIDTH'(2)) begin
                    n_cprime = 1'b0;
                    n_state  = ST_RES;
                end else begin
                    n_cprime = 1'b1;
                    n_state  = ST_CHK;
                end
            end
            ST_CHK: begin
                // Stop once the divisor squared passes the candidate
                if (r_sq > {2'b00, r_c}) begin
                    n_state = ST_RES;
                end else begin
                    w_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    if (w_stat.zero) begin
                        n_cprime = 1'b0;
                        n_state  = ST_RES;
                    end else begin
                        n_sq    = r_sq + SQ_W'({r_d, 1'b1});
                        n_d     = r_d + 1'b1;
                        n_state = ST_CHK;
                    end
                end
            end
            ST_RES: begin
                if (r_op && r_cprime) begin
                    n_count = r_count + 1'b1;
                end
                if (r_c == r_n) begin
                    n_fprime = r_cprime;
                    n_state  = ST_OUT;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = ST_CAND;
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_n      <= n_n;
        r_c      <= n_c;
        r_d      <= n_d;
        r_sq     <= n_sq;
        r_cprime <= n_cprime;
        r_fprime <= n_fprime;
        r_count  <= n_count;
    end

    // Output register: load when empty or being drained, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oprime <= r_fprime;
            r_ocnt   <= r_count;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(pct_pkg::OUT_DATA_W - CW - 1)'(0), r_ocnt, r_oprime};

endmodule

FILE: design/pct_rem.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Reports whether the divisor divides the dividend exactly.
// Depends on pct_pkg.
module pct_rem #(
    parameter int VALUE_WIDTH = pct_pkg::VALUE_WIDTH,
    parameter int DIV_W       = (VALUE_WIDTH + 1) / 2 + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIV_W-1:0]       i_divisor,
    output pct_pkg::t_rem_stat     o_stat
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_num;
    logic [DIV_W-1:0]       r_div;
    logic [DIV_W-1:0]       r_rem;

    logic [DIV_W:0]         w_sh;
    logic                   w_ge;
    logic [DIV_W:0]         w_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_sh   = {r_rem, r_num[VALUE_WIDTH-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    // Control: busy for one cycle per dividend bit, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[VALUE_WIDTH-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

FILE: design/pct_chk.sv
// Port-level checker for the prime test and count block, with its bind.
// Watches only the top-level handshake ports; depends on pct_pkg.
module pct_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [pct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pct_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // Drop ready once a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a request");

    // A new result appears only after a request was being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared with no request in progress");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Keep request fields known while a request is offered
    a_req_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
        else $error("unknown request fields");

endmodule

bind prime_test_and_count pct_chk u_pct_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
